// ===== sv/fpd_pkg.sv =====
package fpd_pkg;

    // Word layout
    localparam int WORD_W   = 32;
    localparam int INT_BITS = 24;
    localparam int FRAC_BITS = 7;
    localparam int SIGN_POS = INT_BITS + FRAC_BITS;

    // Decimal output sizes
    localparam int INT_DIGITS  = 8;
    localparam int FRAC_DIGITS = 7;
    localparam int BCD_W       = 4 * INT_DIGITS;
    localparam int FBCD_W      = 4 * FRAC_DIGITS;
    localparam int ICNT_W      = 4;
    localparam int FCNT_W      = 3;

    // Fraction scaling: floor(frac * 10^7 / 2^FRAC_BITS) always stays below 10^7
    localparam int                FVAL_BITS  = 24;
    localparam logic [FVAL_BITS-1:0] FRAC_SCALE = 24'd10000000;
    localparam int                PROD_W     = FRAC_BITS + FVAL_BITS;

    // One cell per binary bit of the wider of the two values
    localparam int STEPS   = (INT_BITS > FVAL_BITS) ? INT_BITS : FVAL_BITS;
    localparam int LATENCY = STEPS + 2;

    // Data handed from cell to cell
    typedef struct packed {
        logic             neg;
        logic [STEPS-1:0] ibin;
        logic [STEPS-1:0] fbin;
        logic [BCD_W-1:0] ibcd;
        logic [BCD_W-1:0] fbcd;
    } t_cell;

endpackage

// ===== sv/fpd_scale.sv =====
module fpd_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [fpd_pkg::WORD_W-1:0] i_word,
    output logic                       o_vld,
    output fpd_pkg::t_cell             o_cell
);

    logic [fpd_pkg::WORD_W-1:0]     w_word;
    logic [fpd_pkg::FRAC_BITS-1:0]  w_frac;
    logic [fpd_pkg::INT_BITS-1:0]   w_ipart;
    logic [fpd_pkg::PROD_W-1:0]     w_prod;
    logic                           r_vld;
    fpd_pkg::t_cell                 r_cell;
    fpd_pkg::t_cell                 n_cell;

    // Split the word into sign, integer part and fraction
    assign w_word  = i_word;
    assign w_frac  = w_word[fpd_pkg::FRAC_BITS-1:0];
    assign w_ipart = w_word[fpd_pkg::FRAC_BITS +: fpd_pkg::INT_BITS];

    // Scale the fraction to seven decimal digits, truncated
    assign w_prod = fpd_pkg::PROD_W'(w_frac) * fpd_pkg::PROD_W'(fpd_pkg::FRAC_SCALE);

    always_comb begin
        n_cell      = '0;
        n_cell.neg  = w_word[fpd_pkg::SIGN_POS];
        n_cell.ibin = fpd_pkg::STEPS'(w_ipart);
        n_cell.fbin = fpd_pkg::STEPS'(w_prod[fpd_pkg::FRAC_BITS +: fpd_pkg::FVAL_BITS]);
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

// ===== sv/fpd_cell.sv =====
module fpd_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  fpd_pkg::t_cell i_cell,
    output logic           o_vld,
    output fpd_pkg::t_cell o_cell
);

    logic [fpd_pkg::BCD_W-1:0] w_iadj;
    logic [fpd_pkg::BCD_W-1:0] w_fadj;
    logic                      r_vld;
    fpd_pkg::t_cell            r_cell;
    fpd_pkg::t_cell            n_cell;

    // Add three to every digit of five or more, then shift in the next bit
    always_comb begin
        w_iadj = i_cell.ibcd;
        w_fadj = i_cell.fbcd;
        for (int d = 0; d < fpd_pkg::INT_DIGITS; d++) begin
            if (i_cell.ibcd[4*d +: 4] >= 4'd5) begin
                w_iadj[4*d +: 4] = i_cell.ibcd[4*d +: 4] + 4'd3;
            end
            if (i_cell.fbcd[4*d +: 4] >= 4'd5) begin
                w_fadj[4*d +: 4] = i_cell.fbcd[4*d +: 4] + 4'd3;
            end
        end
        n_cell.neg  = i_cell.neg;
        n_cell.ibcd = {w_iadj[fpd_pkg::BCD_W-2:0], i_cell.ibin[fpd_pkg::STEPS-1]};
        n_cell.fbcd = {w_fadj[fpd_pkg::BCD_W-2:0], i_cell.fbin[fpd_pkg::STEPS-1]};
        n_cell.ibin = {i_cell.ibin[fpd_pkg::STEPS-2:0], 1'b0};
        n_cell.fbin = {i_cell.fbin[fpd_pkg::STEPS-2:0], 1'b0};
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

// ===== sv/fpd_count.sv =====
module fpd_count (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  fpd_pkg::t_cell              i_cell,
    output logic                        o_valid,
    output logic                        o_negative,
    output logic [fpd_pkg::BCD_W-1:0]   o_integer_bcd,
    output logic [fpd_pkg::ICNT_W-1:0]  o_integer_digit_count,
    output logic [fpd_pkg::FBCD_W-1:0]  o_fraction_bcd,
    output logic [fpd_pkg::FCNT_W-1:0]  o_fraction_digit_count
);

    logic [fpd_pkg::FBCD_W-1:0] w_fbcd;
    logic [fpd_pkg::ICNT_W-1:0] n_icnt;
    logic [fpd_pkg::FCNT_W-1:0] n_fcnt;
    logic                       r_valid;
    logic                       r_neg;
    logic [fpd_pkg::BCD_W-1:0]  r_ibcd;
    logic [fpd_pkg::ICNT_W-1:0] r_icnt;
    logic [fpd_pkg::FBCD_W-1:0] r_fbcd;
    logic [fpd_pkg::FCNT_W-1:0] r_fcnt;

    assign w_fbcd = i_cell.fbcd[fpd_pkg::FBCD_W-1:0];

    // Count significant integer digits and kept fraction digits
    always_comb begin
        n_icnt = fpd_pkg::ICNT_W'(1);
        for (int i = 0; i < fpd_pkg::INT_DIGITS; i++) begin
            if (i_cell.ibcd[4*i +: 4] != 4'd0) begin
                n_icnt = fpd_pkg::ICNT_W'(i + 1);
            end
        end
        n_fcnt = fpd_pkg::FCNT_W'(1);
        for (int i = fpd_pkg::FRAC_DIGITS - 1; i >= 0; i--) begin
            if (w_fbcd[4*i +: 4] != 4'd0) begin
                n_fcnt = fpd_pkg::FCNT_W'(fpd_pkg::FRAC_DIGITS - i);
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_vld;
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        r_neg  <= i_cell.neg;
        r_ibcd <= i_cell.ibcd;
        r_icnt <= n_icnt;
        r_fbcd <= w_fbcd;
        r_fcnt <= n_fcnt;
    end

    assign o_valid                = r_valid;
    assign o_negative             = r_neg;
    assign o_integer_bcd          = r_ibcd;
    assign o_integer_digit_count  = r_icnt;
    assign o_fraction_bcd         = r_fbcd;
    assign o_fraction_digit_count = r_fcnt;

endmodule

// ===== sv/fixed_point_to_decimal_digits_top.sv =====
// Pipeline: one scaling stage, one shift-and-add-three cell per binary bit,
// one digit count stage, from an accepted start to the o_valid strobe.
// Throughput: one item every cycle; busy stays low, so start may be held high.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset (i_rst_n low, synchronous) clears every stage's valid flag.
module fixed_point_to_decimal_digits_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [fpd_pkg::WORD_W-1:0]  i_word,
    output logic                        o_valid,
    output logic                        o_negative,
    output logic [fpd_pkg::BCD_W-1:0]   o_integer_bcd,
    output logic [fpd_pkg::ICNT_W-1:0]  o_integer_digit_count,
    output logic [fpd_pkg::FBCD_W-1:0]  o_fraction_bcd,
    output logic [fpd_pkg::FCNT_W-1:0]  o_fraction_digit_count
);

    logic                  w_vld  [fpd_pkg::STEPS+1];
    fpd_pkg::t_cell        w_cell [fpd_pkg::STEPS+1];

    // Never hold off an item
    assign busy = 1'b0;

    // Split the word and scale the fraction
    fpd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_word  (i_word),
        .o_vld   (w_vld[0]),
        .o_cell  (w_cell[0])
    );

    // Shift one bit of each value into the digits per cell
    for (genvar g = 0; g < fpd_pkg::STEPS; g++) begin : g_cell
        fpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_cell  (w_cell[g]),
            .o_vld   (w_vld[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    // Count digits and register the result
    fpd_count u_count (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_vld                  (w_vld[fpd_pkg::STEPS]),
        .i_cell                 (w_cell[fpd_pkg::STEPS]),
        .o_valid                (o_valid),
        .o_negative             (o_negative),
        .o_integer_bcd          (o_integer_bcd),
        .o_integer_digit_count  (o_integer_digit_count),
        .o_fraction_bcd         (o_fraction_bcd),
        .o_fraction_digit_count (o_fraction_digit_count)
    );

`ifndef SYNTHESIS
    a_icnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_integer_digit_count >= 4'd1 && o_integer_digit_count <= 4'd8))
        else $error("integer digit count out of range");

    a_fcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fraction_digit_count != 3'd0))
        else $error("fraction digit count is zero");

    a_zero_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_integer_bcd == '0) |-> (o_integer_digit_count == 4'd1))
        else $error("zero integer part must give one digit");

    a_lead_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_integer_digit_count > 4'd1) |->
            ((o_integer_bcd >> (4 * (o_integer_digit_count - 4'd1))) & 32'hF) != 32'd0)
        else $error("leading integer digit is zero");

    a_zero_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fraction_bcd == '0) |-> (o_fraction_digit_count == 3'd1))
        else $error("zero fraction must give one digit");
`endif

endmodule

// ===== tb/sv/fixed_point_to_decimal_digits_checker.sv =====
module fixed_point_to_decimal_digits_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [fpd_pkg::WORD_W-1:0]  i_word,
    input  logic                        i_valid,
    input  logic                        i_negative,
    input  logic [fpd_pkg::BCD_W-1:0]   i_integer_bcd,
    input  logic [fpd_pkg::ICNT_W-1:0]  i_integer_digit_count,
    input  logic [fpd_pkg::FBCD_W-1:0]  i_fraction_bcd,
    input  logic [fpd_pkg::FCNT_W-1:0]  i_fraction_digit_count,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       negative;
        logic [fpd_pkg::BCD_W-1:0]  integer_bcd;
        logic [fpd_pkg::ICNT_W-1:0] integer_digit_count;
        logic [fpd_pkg::FBCD_W-1:0] fraction_bcd;
        logic [fpd_pkg::FCNT_W-1:0] fraction_digit_count;
    } t_decimal;

    t_decimal decimal_q[$];

    // Split the word, turn both parts into BCD and count the digits that are kept
    function automatic t_decimal to_decimal(logic [fpd_pkg::WORD_W-1:0] w);
        t_decimal          r;
        int unsigned       ival;
        longint unsigned   fval;
        logic [3:0]        digit;
        r = '0;
        r.negative = w[fpd_pkg::SIGN_POS];
        ival = 32'(w[fpd_pkg::SIGN_POS-1:fpd_pkg::FRAC_BITS]);
        r.integer_digit_count = fpd_pkg::ICNT_W'(1);
        for (int i = 0; i < fpd_pkg::INT_DIGITS; i++) begin
            digit = 4'(ival % 10);
            r.integer_bcd[4*i +: 4] = digit;
            ival = ival / 10;
            if (digit != 0 || ival != 0) begin
                r.integer_digit_count = fpd_pkg::ICNT_W'(i + 1);
            end
        end
        // scale the fraction to seven decimal places, truncated
        fval = (longint'(w[fpd_pkg::FRAC_BITS-1:0]) * 64'd10000000) >> fpd_pkg::FRAC_BITS;
        r.fraction_digit_count = '0;
        for (int i = 0; i < fpd_pkg::FRAC_DIGITS; i++) begin
            digit = 4'(fval % 10);
            r.fraction_bcd[4*i +: 4] = digit;
            fval = fval / 10;
            if (digit != 0 && r.fraction_digit_count == 0) begin
                r.fraction_digit_count = fpd_pkg::FCNT_W'(fpd_pkg::FRAC_DIGITS - i);
            end
        end
        if (r.fraction_digit_count == 0) begin
            r.fraction_digit_count = fpd_pkg::FCNT_W'(1);
        end
        return r;
    endfunction

    // Compare each strobed result with the oldest pending word, then queue new words
    always @(posedge i_clk) begin
        t_decimal want;
        int       errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_valid) begin
                if (decimal_q.size() == 0) begin
                    $error("result strobed with no word pending");
                    errs++;
                end else begin
                    want = decimal_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_negative !== want.negative) begin
                        $error("negative: expected %0d, got %0d",
                               want.negative, i_negative);
                        errs++;
                    end
                    if (i_integer_bcd !== want.integer_bcd) begin
                        $error("integer_bcd: expected %h, got %h",
                               want.integer_bcd, i_integer_bcd);
                        errs++;
                    end
                    if (i_integer_digit_count !== want.integer_digit_count) begin
                        $error("integer_digit_count: expected %0d, got %0d",
                               want.integer_digit_count, i_integer_digit_count);
                        errs++;
                    end
                    if (i_fraction_bcd !== want.fraction_bcd) begin
                        $error("fraction_bcd: expected %h, got %h",
                               want.fraction_bcd, i_fraction_bcd);
                        errs++;
                    end
                    if (i_fraction_digit_count !== want.fraction_digit_count) begin
                        $error("fraction_digit_count: expected %0d, got %0d",
                               want.fraction_digit_count, i_fraction_digit_count);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                decimal_q.push_back(to_decimal(i_word));
            end
            o_fail_count <= o_fail_count + errs;
            o_pending <= decimal_q.size();
        end else begin
            o_fail_count <= 0;
            o_pending    <= 0;
            o_checked    <= 0;
        end
    end

endmodule

// ===== tb/sv/fixed_point_to_decimal_digits_top_tb.sv =====
module fixed_point_to_decimal_digits_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 560;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DIRECTED_COUNT   = 20;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [fpd_pkg::WORD_W-1:0]    i_word = '0;
    logic                          busy;
    logic                          o_valid;
    logic                          o_negative;
    logic [fpd_pkg::BCD_W-1:0]     o_integer_bcd;
    logic [fpd_pkg::ICNT_W-1:0]    o_integer_digit_count;
    logic [fpd_pkg::FBCD_W-1:0]    o_fraction_bcd;
    logic [fpd_pkg::FCNT_W-1:0]    o_fraction_digit_count;

    int                            fail_count;
    int                            pending;
    int                            checked;
    int                            cycle_count = 0;
    int                            words_sent = 0;
    logic [fpd_pkg::WORD_W-1:0]    directed_words [0:DIRECTED_COUNT-1];

    always #10 i_clk = ~i_clk;

    fixed_point_to_decimal_digits_top dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_word                 (i_word),
        .o_valid                (o_valid),
        .o_negative             (o_negative),
        .o_integer_bcd          (o_integer_bcd),
        .o_integer_digit_count  (o_integer_digit_count),
        .o_fraction_bcd         (o_fraction_bcd),
        .o_fraction_digit_count (o_fraction_digit_count)
    );

    fixed_point_to_decimal_digits_checker checker_u (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_start                (start),
        .i_busy                 (busy),
        .i_word                 (i_word),
        .i_valid                (o_valid),
        .i_negative             (o_negative),
        .i_integer_bcd          (o_integer_bcd),
        .i_integer_digit_count  (o_integer_digit_count),
        .i_fraction_bcd         (o_fraction_bcd),
        .i_fraction_digit_count (o_fraction_digit_count),
        .o_fail_count           (fail_count),
        .o_pending              (pending),
        .o_checked              (checked)
    );

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fixed_point_to_decimal_digits_top: mismatch");
            $finish;
        end
    end

    // Build a word that favors digit-count edges and short or trimmed fractions
    function automatic logic [fpd_pkg::WORD_W-1:0] random_word();
        logic [fpd_pkg::INT_BITS-1:0]  ipart;
        logic [fpd_pkg::FRAC_BITS-1:0] frac;
        int unsigned                   ndig;
        int unsigned                   lo;
        int unsigned                   hi;
        int unsigned                   kind;
        kind = $urandom_range(0, 9);
        ipart = fpd_pkg::INT_BITS'($urandom);
        frac = fpd_pkg::FRAC_BITS'($urandom);
        if (kind >= 4 && kind <= 6) begin
            ndig = $urandom_range(1, fpd_pkg::INT_DIGITS);
            hi = 1;
            repeat (ndig) hi = hi * 10;
            lo = (ndig == 1) ? 0 : hi / 10;
            hi = hi - 1;
            if (hi > (1 << fpd_pkg::INT_BITS) - 1) begin
                hi = (1 << fpd_pkg::INT_BITS) - 1;
            end
            ipart = fpd_pkg::INT_BITS'($urandom_range(hi, lo));
        end else if (kind == 7) begin
            ipart = fpd_pkg::INT_BITS'($urandom_range(0, 20));
            frac = $urandom_range(0, 1) ? '0 :
                fpd_pkg::FRAC_BITS'(1 << $urandom_range(0, fpd_pkg::FRAC_BITS - 1));
        end else if (kind == 8) begin
            hi = 1;
            repeat ($urandom_range(0, fpd_pkg::INT_DIGITS - 1)) hi = hi * 10;
            ipart = fpd_pkg::INT_BITS'(hi + $urandom_range(0, 2) - 1);
        end else if (kind == 9) begin
            frac = frac & ~fpd_pkg::FRAC_BITS'(
                (1 << $urandom_range(0, fpd_pkg::FRAC_BITS - 1)) - 1);
        end
        return {1'($urandom), ipart, frac};
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic [fpd_pkg::WORD_W-1:0] w, input int idle_pct);
        logic was_busy;
        int   gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_word <= w;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
        words_sent++;
    endtask

    initial begin
        directed_words = '{
            32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h0000_0001, 32'h0000_007F, 32'h0000_0040, 32'h0000_0020,
            32'h0000_0080, 32'h0000_0480, 32'h0000_0500, 32'h0000_3180,
            32'h4C4B_4000, 32'h4C4B_3F80, 32'h7FFF_FF80, 32'h8000_0001,
            32'h5E30_A755, 32'h0000_0081, 32'hAAAA_AAAA, 32'h5555_5555
        };

        // Hold reset low, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Edge values first, then random words under three gap settings
        foreach (directed_words[k]) send_word(directed_words[k], 36);
        repeat (RANDOM_PER_PHASE) send_word(random_word(), 36);
        repeat (RANDOM_PER_PHASE) send_word(random_word(), 55);
        repeat (RANDOM_PER_PHASE) send_word(random_word(), 0);
        start <= 1'b0;

        // Drain the pipeline, then allow stray strobes to show up
        do @(negedge i_clk); while (pending != 0);
        repeat (fpd_pkg::LATENCY + 4) @(posedge i_clk);

        $display("Sent %0d words (%0d edge cases, the rest random) and compared %0d results;",
                 words_sent, DIRECTED_COUNT, checked);
        $display("gaps ran at 36%%, 55%% and 0%% of cycles, %0d field errors seen.", fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("fixed_point_to_decimal_digits_top: match");
        end else begin
            $display("fixed_point_to_decimal_digits_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fpd_pkg.sv
sv/fpd_scale.sv
sv/fpd_cell.sv
sv/fpd_count.sv
sv/fixed_point_to_decimal_digits_top.sv
tb/sv/fixed_point_to_decimal_digits_checker.sv
tb/sv/fixed_point_to_decimal_digits_top_tb.sv
